/* rtl/mess_pkg.sv */
package mess_pkg;

    localparam int SIZE_W        = 31;
    localparam int MAX_BOXES_DEF = 1024;
    localparam int TOTAL_W       = SIZE_W + 1;
    localparam int STEP_W        = $clog2(SIZE_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_SCAN,
        S_LOAD,
        S_DIV
    } state_t;

    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/max_equal_share_search_core.sv */
// Channel   Ports                                   Handshake
// command   box_size, wanted_count, last_box        beat taken when start && !busy
// result    best_share                              beat valid while done, one cycle
//
// A box without the last mark is stored while busy stays low.
// A last box runs a binary search over the share, about log2(largest box) passes;
// each pass reads up to N stored boxes one at a time, each through the registered
// read of the box store and the single one-bit-per-cycle divider.
// Reset clears the control state; the box store is not cleared, only entries
// below the box count are read. The receiver cannot stall: done is a strobe.
module max_equal_share_search_core #(
    parameter int MAX_BOXES = mess_pkg::MAX_BOXES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mess_pkg::SIZE_W-1:0] box_size,
    input  logic [mess_pkg::SIZE_W-1:0] wanted_count,
    input  logic                        last_box,
    output logic                        done,
    output logic [mess_pkg::SIZE_W-1:0] best_share
);
    import mess_pkg::*;

    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   box_count_reg, box_count_next;
    logic [SIZE_W-1:0]  largest_reg, largest_next;
    logic               done_reg, done_next;
    logic [SIZE_W-1:0]  best_share_reg, best_share_next;
    logic [SIZE_W-1:0]  need_reg, need_next;
    logic [TOTAL_W-1:0] lo_reg, lo_next;
    logic [TOTAL_W-1:0] hi_reg, hi_next;
    logic [SIZE_W-1:0]  mid_reg, mid_next;
    logic [SIZE_W-1:0]  best_reg, best_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic               accept;
    logic               store_ok;
    logic [SIZE_W-1:0]  largest_upd;
    logic [TOTAL_W-1:0] span;
    logic [TOTAL_W-1:0] mid_wide;
    logic [SIZE_W-1:0]  rd_data;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    mess_ram #(
        .WIDTH  (SIZE_W),
        .DEPTH  (MAX_BOXES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (accept && store_ok),
        .waddr (box_count_reg[ADDR_W-1:0]),
        .wdata (box_size),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    mess_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept           = start && (state_reg == S_IDLE);
    assign store_ok         = box_count_reg < CNT_W'(MAX_BOXES);
    assign largest_upd      = (box_size > largest_reg) ? box_size : largest_reg;
    assign span             = hi_reg - lo_reg;
    assign mid_wide         = lo_reg + (span >> 1);
    assign div_req.start    = (state_reg == S_LOAD);
    assign div_req.dividend = rd_data;
    assign div_req.divisor  = mid_reg;

    always_comb
    begin
        state_next      = state_reg;
        box_count_next  = box_count_reg;
        largest_next    = largest_reg;
        done_next       = 1'b0;
        best_share_next = best_share_reg;
        need_next       = need_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        best_next       = best_reg;
        idx_next        = idx_reg;
        total_next      = total_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (store_ok)
                    begin
                        box_count_next = box_count_reg + 1'b1;
                        largest_next   = largest_upd;
                    end
                    if (last_box)
                    begin
                        need_next  = wanted_count;
                        lo_next    = TOTAL_W'(1);
                        hi_next    = {1'b0, store_ok ? largest_upd : largest_reg};
                        best_next  = '0;
                        state_next = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                if (lo_reg > hi_reg)
                begin
                    best_share_next = best_reg;
                    done_next       = 1'b1;
                    box_count_next  = '0;
                    largest_next    = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    mid_next   = mid_wide[SIZE_W-1:0];
                    idx_next   = '0;
                    total_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (total_reg >= {1'b0, need_reg})
                begin
                    best_next  = mid_reg;
                    lo_next    = {1'b0, mid_reg} + 1'b1;
                    state_next = S_PASS;
                end
                else if (idx_reg == box_count_reg)
                begin
                    hi_next    = {1'b0, mid_reg} - 1'b1;
                    state_next = S_PASS;
                end
                else
                begin
                    // read address is idx; data lands next cycle
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    // total stays below need before the add, so no overflow
                    total_next = total_reg + {1'b0, div_rsp.quotient};
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_count_reg <= '0;
            largest_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            largest_reg   <= largest_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_share_reg <= best_share_next;
        need_reg       <= need_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        best_reg       <= best_next;
        idx_reg        <= idx_next;
        total_reg      <= total_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign best_share = best_share_reg;

endmodule

/* rtl/mess_ram.sv */
module mess_ram #(
    parameter int WIDTH  = 31,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mess_divider.sv */
module mess_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  mess_pkg::div_req_t req,
    output mess_pkg::div_rsp_t rsp
);
    import mess_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] dq_reg, dq_next;
    logic [SIZE_W-1:0] divisor_reg, divisor_next;

    logic [SIZE_W:0]   shifted;
    logic [SIZE_W+1:0] diff;
    logic              borrow;

    always_comb
    begin
        shifted      = {rem_reg, dq_reg[SIZE_W-1]};
        diff         = {1'b0, shifted} - {2'b00, divisor_reg};
        borrow       = diff[SIZE_W+1];
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            step_next    = STEP_W'(SIZE_W - 1);
            rem_next     = '0;
            dq_next      = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            // restore on borrow, shift quotient bit in from the right
            rem_next = borrow ? shifted[SIZE_W-1:0] : diff[SIZE_W-1:0];
            dq_next  = {dq_reg[SIZE_W-2:0], ~borrow};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

/* rtl/mess_checker.sv */
module mess_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_box,
    input logic done
);

    // a result only closes a search
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding search");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    // a plain box beat leaves busy low and raises no result in the next cycle
    a_plain_box_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_box) |=> (!busy && !done))
        else $error("box beat without last mark stalled the block");

    a_last_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_box) |=> busy)
        else $error("last box beat did not start a search");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

bind max_equal_share_search_core mess_checker u_checker (.*);

/* bench/max_equal_share_search_core_tb.sv */
`timescale 1ns / 1ps

module max_equal_share_search_core_tb;
    import mess_pkg::*;

    localparam int MAX_BOXES      = MAX_BOXES_DEF;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_GAP        = 13;
    localparam int RANDOM_ITEMS   = 580;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = 64;
    // slowest directed search: full store, two passes of 1024 divides each
    localparam int WATCHDOG_LIMIT = 400000;

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [SIZE_W-1:0] box_size;
    logic [SIZE_W-1:0] wanted_count;
    logic              last_box;
    logic              done;
    logic [SIZE_W-1:0] best_share;

    max_equal_share_search_core #(
        .MAX_BOXES (MAX_BOXES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .box_size     (box_size),
        .wanted_count (wanted_count),
        .last_box     (last_box),
        .done         (done),
        .best_share   (best_share)
    );

    // mirror of the box set held by the block
    logic [SIZE_W-1:0] model_boxes [MAX_BOXES];
    int unsigned       model_count;
    logic [SIZE_W-1:0] model_largest;
    logic [SIZE_W-1:0] expected_shares [$];
    logic [SIZE_W-1:0] share_due;

    int  error_count;
    int  mismatch_count;
    int  sets_sent;
    int  boxes_sent;
    int  results_seen;
    int  idle_cycles;
    bit  gapless;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic bit share_fits(input logic [SIZE_W-1:0] share,
                                      input logic [SIZE_W-1:0] need);
        logic [63:0] total;
        total = '0;
        for (int i = 0; i < model_count; i++)
        begin
            total += 64'(model_boxes[i] / share);
            // stop early so the sum never wraps
            if (total >= 64'(need))
                return 1'b1;
        end
        return total >= 64'(need);
    endfunction

    function automatic logic [SIZE_W-1:0] predict_best_share(input logic [SIZE_W-1:0] need);
        logic [SIZE_W:0]   lo;
        logic [SIZE_W:0]   hi;
        logic [SIZE_W:0]   mid;
        logic [SIZE_W-1:0] best;
        lo   = 1;
        hi   = {1'b0, model_largest};
        best = '0;
        while (lo <= hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (share_fits(mid[SIZE_W-1:0], need))
            begin
                best = mid[SIZE_W-1:0];
                lo   = mid + 1;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return best;
    endfunction

    task automatic absorb_box(input logic [SIZE_W-1:0] size,
                              input logic [SIZE_W-1:0] need,
                              input logic              last);
        // drop boxes once the store is full
        if (model_count < MAX_BOXES)
        begin
            model_boxes[model_count] = size;
            model_count++;
            if (size > model_largest)
                model_largest = size;
        end
        if (last)
        begin
            expected_shares.push_back(predict_best_share(need));
            model_count   = 0;
            model_largest = '0;
            sets_sent++;
        end
        boxes_sent++;
    endtask

    // enter and leave at a falling edge; start stays high into the next beat when no gap
    task automatic send_box(input logic [SIZE_W-1:0] size,
                            input logic [SIZE_W-1:0] need,
                            input logic              last);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        box_size     <= size;
        wanted_count <= need;
        last_box     <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        absorb_box(size, need, last);
        @(negedge clk);
    endtask

    task automatic test_single_box_extremes;
        send_box('0, 1, 1'b1);
        send_box(SIZE_MAX, 1, 1'b1);
        send_box(SIZE_MAX, SIZE_MAX, 1'b1);
        send_box(1, SIZE_MAX, 1'b1);
        send_box(SIZE_MAX, '0, 1'b1);
    endtask

    task automatic test_zero_wanted;
        send_box(5, SIZE_MAX, 1'b0);
        send_box(900, 3, 1'b0);
        send_box(17, '0, 1'b1);
    endtask

    task automatic test_all_zero_boxes;
        send_box('0, '0, 1'b0);
        send_box('0, '0, 1'b0);
        send_box('0, 1, 1'b1);
        send_box('0, '0, 1'b1);
    endtask

    task automatic test_mixed_sets;
        send_box(802, '0, 1'b0);
        send_box(743, '0, 1'b0);
        send_box(457, '0, 1'b0);
        send_box(539, 11, 1'b1);
        send_box(SIZE_MAX, '0, 1'b0);
        send_box(SIZE_MAX - 1, '0, 1'b0);
        send_box(1, 3, 1'b1);
    endtask

    task automatic test_store_full;
        for (int i = 0; i < MAX_BOXES; i++)
            send_box(2, SIZE_W'($urandom), 1'b0);
        // both overflow boxes are dropped, so the large size must not count
        send_box(SIZE_MAX, SIZE_W'($urandom), 1'b0);
        send_box(SIZE_MAX, 2 * MAX_BOXES, 1'b1);
    endtask

    task automatic test_random_sets;
        logic [SIZE_W-1:0] sizes [16];
        logic [SIZE_W-1:0] need;
        logic [SIZE_W-1:0] pick;
        logic [SIZE_W-1:0] largest;
        logic [63:0]       sum;
        int                n;
        int                size_mode;
        int                need_mode;
        int                items;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            gapless   = ($urandom_range(0, 3) == 0);
            n         = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                    : $urandom_range(1, 6);
            size_mode = $urandom_range(0, 3);
            largest   = '0;
            for (int i = 0; i < n; i++)
            begin
                case (size_mode)
                    0: sizes[i] = SIZE_W'($urandom);
                    1: sizes[i] = SIZE_W'($urandom_range(0, 15));
                    2: sizes[i] = SIZE_W'($urandom >> $urandom_range(0, 31));
                    default: sizes[i] = ($urandom_range(0, 2) == 0) ? '0
                                        : SIZE_W'($urandom_range(0, 100000));
                endcase
                if (sizes[i] > largest)
                    largest = sizes[i];
            end
            need_mode = $urandom_range(0, 7);
            case (need_mode)
                0: need = '0;
                1: need = SIZE_W'($urandom);
                2, 3, 4: need = SIZE_W'($urandom_range(1, 4 * n));
                default:
                begin
                    // land on or just past the count for some share
                    pick = (largest == 0) ? 1 : SIZE_W'($urandom_range(1, largest));
                    sum  = 64'($urandom_range(0, 1));
                    for (int i = 0; i < n; i++)
                        sum += 64'(sizes[i] / pick);
                    need = (sum > 64'(SIZE_MAX)) ? SIZE_MAX : sum[SIZE_W-1:0];
                end
            endcase
            for (int i = 0; i < n; i++)
                send_box(sizes[i], (i == n - 1) ? need : SIZE_W'($urandom), i == n - 1);
            items += n;
        end
        gapless = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_shares.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result beat: best_share=%0d", best_share);
            end
            else
            begin
                share_due = expected_shares.pop_front();
                if (best_share !== share_due)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("best_share mismatch: expected %0d, got %0d",
                                 share_due, best_share);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        box_size      = '0;
        wanted_count  = '0;
        last_box      = 1'b0;
        gapless       = 1'b0;
        model_count   = 0;
        model_largest = '0;
        error_count   = 0;
        mismatch_count = 0;
        sets_sent     = 0;
        boxes_sent    = 0;
        results_seen  = 0;
        idle_cycles   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_box_extremes();
        test_zero_wanted();
        test_all_zero_boxes();
        test_mixed_sets();
        test_store_full();
        test_random_sets();
        start <= 1'b0;

        while (expected_shares.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d boxes in %0d sets (single-box extremes, zero count, zero boxes,",
                 boxes_sent, sets_sent);
        $display("full store with dropped boxes, random sets); %0d results checked",
                 results_seen);
        if (error_count == 0 && expected_shares.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mess_pkg.sv
rtl/mess_ram.sv
rtl/mess_divider.sv
rtl/max_equal_share_search_core.sv
rtl/mess_checker.sv
bench/max_equal_share_search_core_tb.sv
